### design/mcwf_pkg.sv
// ----------------------------------------------------------------------------
// Minimum covering window finder: shared package
// Sizes, payload structs, operation codes and the back-end state type.
// ----------------------------------------------------------------------------
package mcwf_pkg;

  // Store sizes.
  localparam int MAX_TEXT    = 1024;
  localparam int MAX_PATTERN = 256;
  localparam int SYMBOLS     = 256;
  localparam int QUEUE_DEPTH = 4;

  // Derived widths.
  localparam int SYM_W   = 8;
  localparam int SYM_AW  = $clog2(SYMBOLS);
  localparam int TEXT_AW = $clog2(MAX_TEXT);
  localparam int EDGE_W  = $clog2(MAX_TEXT + 1);
  localparam int PAT_W   = $clog2(MAX_PATTERN + 1);
  localparam int NEED_MAG = (MAX_TEXT > MAX_PATTERN) ? MAX_TEXT : MAX_PATTERN;
  localparam int NEED_W  = $clog2(NEED_MAG + 1) + 1;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Fixed result field widths.
  localparam int START_W = 10;
  localparam int LEN_W   = 11;

  // Input mode codes.
  localparam logic [1:0] MODE_PATTERN = 2'd0;
  localparam logic [1:0] MODE_TEXT    = 2'd1;
  localparam logic [1:0] MODE_END     = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]       mode;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic               found;
    logic [START_W-1:0] window_start;
    logic [LEN_W-1:0]   window_length;
    logic               overflow;
  } out_item_t;

  // Classified operation held in the queue.
  typedef enum logic [1:0] {
    OP_PATTERN,
    OP_TEXT,
    OP_END
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
  } cmd_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } q_head_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_UPD,
    ST_TXT_UPD,
    ST_SHR_BEST,
    ST_SHR_SYM,
    ST_SHR_UPD
  } bk_state_t;

endpackage

### design/mcwf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mcwf_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts input transactions, classifies the mode and queues the operation.
// ----------------------------------------------------------------------------
module mcwf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mcwf_pkg::in_item_t in_data,
  output mcwf_pkg::q_head_t head,
  input  logic              pop
);

  mcwf_pkg::cmd_t                 q_r [mcwf_pkg::QUEUE_DEPTH];
  logic [mcwf_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mcwf_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mcwf_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           keep;
  mcwf_pkg::op_t                  op;
  logic                           push;

  // Mode decoder; the unused code is accepted and dropped.
  always_comb begin
    keep = 1'b1;
    op   = mcwf_pkg::OP_PATTERN;
    unique case (in_data.mode)
      mcwf_pkg::MODE_PATTERN: op = mcwf_pkg::OP_PATTERN;
      mcwf_pkg::MODE_TEXT:    op = mcwf_pkg::OP_TEXT;
      mcwf_pkg::MODE_END:     op = mcwf_pkg::OP_END;
      default:                keep = 1'b0;
    endcase
  end

  assign in_stall = (cnt_r == mcwf_pkg::QCNT_W'(mcwf_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && keep;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mcwf_pkg::QPTR_W'(mcwf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + mcwf_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mcwf_pkg::QPTR_W'(mcwf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + mcwf_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + mcwf_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - mcwf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op, sym: in_data.symbol};
    end
  end

  assign head.avail = (cnt_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

endmodule

### design/mcwf_back.sv
// ----------------------------------------------------------------------------
// Back end
// Runs the need table and text store, slides the window and builds results.
// ----------------------------------------------------------------------------
module mcwf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mcwf_pkg::q_head_t  head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mcwf_pkg::out_item_t out_data
);

  localparam int NW = mcwf_pkg::NEED_W;

  mcwf_pkg::bk_state_t              state_r, state_nxt;
  logic [mcwf_pkg::EDGE_W-1:0]      left_r, left_nxt;
  logic [mcwf_pkg::EDGE_W-1:0]      right_r, right_nxt;
  logic [mcwf_pkg::TEXT_AW-1:0]     best_start_r, best_start_nxt;
  logic [mcwf_pkg::EDGE_W-1:0]      best_len_r, best_len_nxt;
  logic                             best_vld_r, best_vld_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [mcwf_pkg::PAT_W-1:0]       pat_seen_r, pat_seen_nxt;
  logic [mcwf_pkg::PAT_W-1:0]       missing_r, missing_nxt;
  logic [mcwf_pkg::SYM_W-1:0]       sym_r, sym_nxt;
  logic [mcwf_pkg::SYMBOLS-1:0]     need_vld_r, need_vld_nxt;
  logic                             vld_q_r;
  logic                             out_valid_r, out_valid_nxt;
  mcwf_pkg::out_item_t              out_data_r, out_data_nxt;

  logic                             need_we;
  logic [mcwf_pkg::SYM_AW-1:0]      need_wa, need_ra;
  logic [NW-1:0]                    need_wd, need_rdata;
  logic [NW-1:0]                    need_val, need_inc, need_dec;
  logic                             text_we;
  logic [mcwf_pkg::SYM_W-1:0]       text_rdata;
  logic [mcwf_pkg::EDGE_W-1:0]      win_len;
  logic [mcwf_pkg::EDGE_W-1:0]      left_inc;
  logic                             out_free;
  logic                             pat_ok, txt_ok, txt_search;
  logic                             val_pos, inc_pos;
  logic [mcwf_pkg::PAT_W-1:0]       miss_after_txt;
  logic                             txt_cont, shr_cont;

  // Need table: one counter per byte value; a clear entry reads as zero.
  mcwf_ram #(.WIDTH(NW), .DEPTH(mcwf_pkg::SYMBOLS)) u_need_ram (
    .clk   (clk),
    .we    (need_we),
    .waddr (need_wa),
    .wdata (need_wd),
    .raddr (need_ra),
    .rdata (need_rdata)
  );

  // Text store, written at the right edge and read at the left edge.
  mcwf_ram #(.WIDTH(mcwf_pkg::SYM_W), .DEPTH(mcwf_pkg::MAX_TEXT)) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (right_r[mcwf_pkg::TEXT_AW-1:0]),
    .wdata (head.cmd.sym),
    .raddr (left_r[mcwf_pkg::TEXT_AW-1:0]),
    .rdata (text_rdata)
  );

  // Shared decode terms.
  assign need_val = vld_q_r ? need_rdata : '0;
  assign need_inc = need_val + NW'(1);
  assign need_dec = need_val - NW'(1);
  assign val_pos  = !need_val[NW-1] && (need_val != '0);
  assign inc_pos  = !need_inc[NW-1] && (need_inc != '0);
  assign win_len  = right_r - left_r;
  assign left_inc = left_r + mcwf_pkg::EDGE_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  assign pat_ok     = (right_r == '0) && (pat_seen_r < mcwf_pkg::PAT_W'(mcwf_pkg::MAX_PATTERN));
  assign txt_ok     = (right_r < mcwf_pkg::EDGE_W'(mcwf_pkg::MAX_TEXT));
  assign txt_search = txt_ok && (missing_r != '0);
  assign miss_after_txt = val_pos ? missing_r - mcwf_pkg::PAT_W'(1) : missing_r;
  assign txt_cont   = (miss_after_txt == '0) && (left_r < right_r);
  assign shr_cont   = !inc_pos && (left_inc < right_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcwf_pkg::ST_IDLE: begin
        if (head.avail) begin
          case (head.cmd.op)
            mcwf_pkg::OP_PATTERN: if (pat_ok) state_nxt = mcwf_pkg::ST_PAT_UPD;
            mcwf_pkg::OP_TEXT:    if (txt_search) state_nxt = mcwf_pkg::ST_TXT_UPD;
            default:              state_nxt = mcwf_pkg::ST_IDLE;
          endcase
        end
      end
      mcwf_pkg::ST_PAT_UPD:  state_nxt = mcwf_pkg::ST_IDLE;
      mcwf_pkg::ST_TXT_UPD:  state_nxt = txt_cont ? mcwf_pkg::ST_SHR_BEST : mcwf_pkg::ST_IDLE;
      mcwf_pkg::ST_SHR_BEST: state_nxt = mcwf_pkg::ST_SHR_SYM;
      mcwf_pkg::ST_SHR_SYM:  state_nxt = mcwf_pkg::ST_SHR_UPD;
      mcwf_pkg::ST_SHR_UPD:  state_nxt = shr_cont ? mcwf_pkg::ST_SHR_BEST : mcwf_pkg::ST_IDLE;
      default:               state_nxt = mcwf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    pop            = 1'b0;
    need_we        = 1'b0;
    need_wa        = sym_r;
    need_wd        = need_inc;
    need_ra        = head.cmd.sym;
    text_we        = 1'b0;
    left_nxt       = left_r;
    right_nxt      = right_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    best_vld_nxt   = best_vld_r;
    ovf_nxt        = ovf_r;
    pat_seen_nxt   = pat_seen_r;
    missing_nxt    = missing_r;
    sym_nxt        = sym_r;
    need_vld_nxt   = need_vld_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      mcwf_pkg::ST_IDLE: begin
        if (head.avail) begin
          case (head.cmd.op)
            mcwf_pkg::OP_PATTERN: begin
              pop     = 1'b1;
              sym_nxt = head.cmd.sym;
              if (right_r == '0 && !pat_ok) begin
                ovf_nxt = 1'b1;
              end
            end
            mcwf_pkg::OP_TEXT: begin
              pop     = 1'b1;
              sym_nxt = head.cmd.sym;
              if (txt_ok) begin
                text_we   = 1'b1;
                right_nxt = right_r + mcwf_pkg::EDGE_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            default: begin
              // End of job: report, then return to a clean job state.
              if (out_free) begin
                pop           = 1'b1;
                out_valid_nxt = 1'b1;
                out_data_nxt.overflow = ovf_r;
                if (missing_r == '0 && pat_seen_r == '0) begin
                  out_data_nxt.found         = 1'b1;
                  out_data_nxt.window_start  = '0;
                  out_data_nxt.window_length = '0;
                end else if (best_vld_r) begin
                  out_data_nxt.found         = 1'b1;
                  out_data_nxt.window_start  = mcwf_pkg::START_W'(best_start_r);
                  out_data_nxt.window_length = mcwf_pkg::LEN_W'(best_len_r);
                end else begin
                  out_data_nxt.found         = 1'b0;
                  out_data_nxt.window_start  = '0;
                  out_data_nxt.window_length = '0;
                end
                left_nxt       = '0;
                right_nxt      = '0;
                best_start_nxt = '0;
                best_len_nxt   = '0;
                best_vld_nxt   = 1'b0;
                ovf_nxt        = 1'b0;
                pat_seen_nxt   = '0;
                missing_nxt    = '0;
                need_vld_nxt   = '0;
              end
            end
          endcase
        end
      end
      mcwf_pkg::ST_PAT_UPD: begin
        need_we               = 1'b1;
        need_wd               = need_inc;
        need_vld_nxt[sym_r]   = 1'b1;
        pat_seen_nxt          = pat_seen_r + mcwf_pkg::PAT_W'(1);
        missing_nxt           = missing_r + mcwf_pkg::PAT_W'(1);
      end
      mcwf_pkg::ST_TXT_UPD: begin
        need_we             = 1'b1;
        need_wd             = need_dec;
        need_vld_nxt[sym_r] = 1'b1;
        missing_nxt         = miss_after_txt;
      end
      mcwf_pkg::ST_SHR_BEST: begin
        // Earliest window wins on equal length.
        if (!best_vld_r || win_len < best_len_r) begin
          best_vld_nxt   = 1'b1;
          best_start_nxt = left_r[mcwf_pkg::TEXT_AW-1:0];
          best_len_nxt   = win_len;
        end
      end
      mcwf_pkg::ST_SHR_SYM: begin
        need_ra = text_rdata;
        sym_nxt = text_rdata;
      end
      mcwf_pkg::ST_SHR_UPD: begin
        need_we             = 1'b1;
        need_wd             = need_inc;
        need_vld_nxt[sym_r] = 1'b1;
        left_nxt            = left_inc;
        if (inc_pos) begin
          missing_nxt = missing_r + mcwf_pkg::PAT_W'(1);
        end
      end
      default: begin
        need_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mcwf_pkg::ST_IDLE;
      left_r       <= '0;
      right_r      <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
      best_vld_r   <= 1'b0;
      ovf_r        <= 1'b0;
      pat_seen_r   <= '0;
      missing_r    <= '0;
      need_vld_r   <= '0;
      vld_q_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
      best_vld_r   <= best_vld_nxt;
      ovf_r        <= ovf_nxt;
      pat_seen_r   <= pat_seen_nxt;
      missing_r    <= missing_nxt;
      need_vld_r   <= need_vld_nxt;
      vld_q_r      <= need_vld_r[need_ra];
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/min_covering_window_finder.sv
// ----------------------------------------------------------------------------
// Minimum covering window finder
// Finds the earliest shortest window of a text byte stream that holds every
// pattern byte with its full multiplicity.
//
//   Channel  Ports                          Carries
//   input    in_valid, in_stall, in_data    pattern byte, text byte or end
//   result   out_valid, out_stall, out_data found, start, length, overflow
//
// A pattern byte passes the idle and pattern-update states; a text byte idle
// and, while a pattern byte is still missing, text-update, then for each
// left-edge step a best, a symbol and an update state (a text read, then a
// need-table read and write); an end transaction passes idle only.
// A 4-entry queue keeps accepting while the back end works or a result waits.
// Reset is synchronous; the need table is cleared by valid bits, no sweep.
// ----------------------------------------------------------------------------
module min_covering_window_finder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcwf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcwf_pkg::out_item_t out_data
);

  mcwf_pkg::q_head_t head;
  logic              pop;

  // Accept and classify.
  mcwf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  // Window search and result.
  mcwf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### design/mcwf_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports for result and reset consistency.
// ----------------------------------------------------------------------------
module mcwf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mcwf_pkg::out_item_t out_data
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties both the queue and the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  // A miss reports a zero window.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.window_start == '0 && out_data.window_length == '0)
    else $error("window reported without a match");

  // A found window lies inside the text store.
  a_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      (int'(out_data.window_start) + int'(out_data.window_length)) <= mcwf_pkg::MAX_TEXT)
    else $error("window runs past the text store");

endmodule

bind min_covering_window_finder mcwf_checker u_mcwf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/tb_min_covering_window_finder.sv
// ----------------------------------------------------------------------------
// Minimum covering window finder: self-checking testbench
// Drives pattern, text and end transactions under random valid gaps and
// result stalls. A scoreboard class predicts each job's shortest covering
// window and checks every result against it. The run starts with short
// directed jobs, then runs random jobs, including a pattern-store overflow
// job.
// ----------------------------------------------------------------------------
module tb_min_covering_window_finder;

  // Mode 3 has no meaning; the block must ignore it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Scoreboard: keeps its own copy of the job state and the windows still owed.
  class window_scoreboard;
    int                  need_count [mcwf_pkg::SYMBOLS];
    logic [7:0]          text_copy [mcwf_pkg::MAX_TEXT];
    int                  missing_total;
    int                  left_edge;
    int                  right_edge;
    int                  best_start;
    int                  best_length;
    bit                  best_valid;
    bit                  overflow_seen;
    int                  pattern_seen;
    mcwf_pkg::out_item_t owed_windows [$];
    int                  errors;
    int                  results_checked;
    int                  windows_found;
    int                  overflow_jobs;
    int                  items_taken;

    function new();
      clear_job();
    endfunction

    function void clear_job();
      foreach (need_count[i]) need_count[i] = 0;
      missing_total = 0;
      left_edge     = 0;
      right_edge    = 0;
      best_start    = 0;
      best_length   = 0;
      best_valid    = 1'b0;
      overflow_seen = 1'b0;
      pattern_seen  = 0;
    endfunction

    // Extend the window by one text byte, then shrink it from the left while
    // it still covers the whole pattern.
    function void add_text_byte(logic [7:0] sym);
      logic [7:0] dropped;
      int span;
      if (right_edge >= mcwf_pkg::MAX_TEXT) begin
        overflow_seen = 1'b1;
        return;
      end
      text_copy[right_edge] = sym;
      right_edge++;
      if (missing_total == 0) return;
      if (need_count[sym] > 0) missing_total--;
      need_count[sym]--;
      while (missing_total == 0 && left_edge < right_edge) begin
        span = right_edge - left_edge;
        if (!best_valid || span < best_length) begin
          best_valid  = 1'b1;
          best_start  = left_edge;
          best_length = span;
        end
        dropped = text_copy[left_edge];
        need_count[dropped]++;
        if (need_count[dropped] > 0) missing_total++;
        left_edge++;
      end
    endfunction

    // Record one accepted input transaction.
    function void absorb_item(mcwf_pkg::in_item_t item);
      mcwf_pkg::out_item_t want;
      items_taken++;
      case (item.mode)
        mcwf_pkg::MODE_PATTERN: begin
          if (right_edge == 0) begin
            if (pattern_seen >= mcwf_pkg::MAX_PATTERN) begin
              overflow_seen = 1'b1;
            end else begin
              pattern_seen++;
              need_count[item.symbol]++;
              missing_total++;
            end
          end
        end
        mcwf_pkg::MODE_TEXT: begin
          add_text_byte(item.symbol);
        end
        mcwf_pkg::MODE_END: begin
          want = '0;
          if (missing_total == 0 && pattern_seen == 0) begin
            want.found = 1'b1;
          end else if (best_valid) begin
            want.found         = 1'b1;
            want.window_start  = mcwf_pkg::START_W'(best_start);
            want.window_length = mcwf_pkg::LEN_W'(best_length);
          end
          want.overflow = overflow_seen;
          owed_windows.push_back(want);
          clear_job();
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest owed window.
    function void check_result(mcwf_pkg::out_item_t got);
      mcwf_pkg::out_item_t want;
      if (owed_windows.size() == 0) begin
        $display("%0t: unexpected result found=%0d start=%0d length=%0d overflow=%0d",
                 $time, got.found, got.window_start, got.window_length, got.overflow);
        errors++;
        return;
      end
      want = owed_windows.pop_front();
      results_checked++;
      if (want.found) windows_found++;
      if (want.overflow) overflow_jobs++;
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0d, got %0d",
                 $time, want.found, got.found);
        errors++;
      end
      if (got.window_start !== want.window_start) begin
        $display("%0t: window_start mismatch, expected %0d, got %0d",
                 $time, want.window_start, got.window_start);
        errors++;
      end
      if (got.window_length !== want.window_length) begin
        $display("%0t: window_length mismatch, expected %0d, got %0d",
                 $time, want.window_length, got.window_length);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow mismatch, expected %0d, got %0d",
                 $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mcwf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mcwf_pkg::out_item_t out_data;

  window_scoreboard board = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int job_items = 0;

  // Idling plan per phase: sender gaps and receiver stalls in percent.
  int send_plan [3] = '{11, 77, 0};
  int recv_plan [3] = '{77, 11, 0};

  min_covering_window_finder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock with a period of 2 time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Outputs are settled at the falling edge; a result with valid high and no
  // stall completes its transaction at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_data);
    end
  end

  // Send one transaction, with random gaps before it. Returns at the rising
  // edge that accepts it, with valid still high.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] sym);
    mcwf_pkg::in_item_t item;
    bit taken;
    item.mode   = mode;
    item.symbol = sym;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    board.absorb_item(item);
  endtask

  // Hold the sender off until every owed window has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.owed_windows.size() != 0) @(posedge clk);
  endtask

  // One random job: a pattern and a text drawn from a narrow alphabet so that
  // windows are often found, with some noise mixed in.
  task automatic random_job();
    int pat_len;
    int txt_len;
    int span;
    int base;
    int roll;
    logic [7:0] sym;
    pat_len = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
    txt_len = ($urandom_range(6) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
    span = $urandom_range(1, 10);
    base = $urandom_range(0, 256 - span);
    for (int i = 0; i < pat_len; i++) begin
      if ($urandom_range(49) == 0) begin
        send_item(MODE_UNUSED, 8'($urandom_range(255)));
      end
      send_item(mcwf_pkg::MODE_PATTERN, 8'(base + $urandom_range(span - 1)));
      job_items++;
    end
    for (int i = 0; i < txt_len; i++) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        send_item(MODE_UNUSED, 8'($urandom_range(255)));
      end else if (roll < 4) begin
        // A pattern byte is ignored once text has started; before the first text byte it joins the pattern.
        send_item(mcwf_pkg::MODE_PATTERN, 8'($urandom_range(255)));
      end
      sym = (roll >= 96) ? 8'($urandom_range(255)) : 8'(base + $urandom_range(span - 1));
      send_item(mcwf_pkg::MODE_TEXT, sym);
      job_items++;
    end
    send_item(mcwf_pkg::MODE_END, 8'($urandom_range(255)));
    job_items++;
    if ($urandom_range(19) == 0) drain_results();
  endtask

  // Run limit.
  initial begin
    #1_000_000;
    $display("Timeout: %0d windows still owed", board.owed_windows.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Main stimulus.
  initial begin
    send_idle_pct  = send_plan[0];
    recv_stall_pct = recv_plan[0];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty pattern with no text, then empty pattern with text.
    send_item(mcwf_pkg::MODE_END, 8'h00);
    send_item(mcwf_pkg::MODE_TEXT, 8'h00);
    send_item(mcwf_pkg::MODE_TEXT, 8'hFF);
    send_item(mcwf_pkg::MODE_END, 8'hFF);

    // Extreme symbols, an unknown mode and a late pattern byte inside a job.
    send_item(mcwf_pkg::MODE_PATTERN, 8'hFF);
    send_item(mcwf_pkg::MODE_PATTERN, 8'h00);
    send_item(mcwf_pkg::MODE_TEXT, 8'h00);
    send_item(mcwf_pkg::MODE_TEXT, 8'h55);
    send_item(MODE_UNUSED, 8'hC3);
    send_item(mcwf_pkg::MODE_PATTERN, 8'hAA);
    send_item(mcwf_pkg::MODE_TEXT, 8'hFF);
    send_item(mcwf_pkg::MODE_END, 8'h00);

    // Repeated pattern byte that the text covers only once: not found.
    send_item(mcwf_pkg::MODE_PATTERN, 8'h80);
    send_item(mcwf_pkg::MODE_PATTERN, 8'h80);
    send_item(mcwf_pkg::MODE_TEXT, 8'h80);
    send_item(mcwf_pkg::MODE_TEXT, 8'h01);
    send_item(mcwf_pkg::MODE_END, 8'h00);

    // Pattern with no text at all.
    send_item(mcwf_pkg::MODE_PATTERN, 8'h7F);
    send_item(mcwf_pkg::MODE_END, 8'h00);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = send_plan[ph];
      recv_stall_pct = recv_plan[ph];
      if (ph == 2) begin
        // Pattern store overflow.
        for (int i = 0; i < mcwf_pkg::MAX_PATTERN + 3; i++) begin
          send_item(mcwf_pkg::MODE_PATTERN, 8'($urandom_range(255)));
        end
        for (int i = 0; i < 20; i++) begin
          send_item(mcwf_pkg::MODE_TEXT, 8'($urandom_range(255)));
        end
        send_item(mcwf_pkg::MODE_END, 8'h00);
      end
      job_items = 0;
      while (job_items < 200) random_job();
    end

    // Let every owed window arrive, then watch for stray results.
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.owed_windows.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (board.owed_windows.size() != 0) begin
      $display("%0d expected windows never arrived", board.owed_windows.size());
      board.errors++;
    end
    $display("Sent %0d input transactions and checked %0d results.",
             board.items_taken, board.results_checked);
    $display("Of those, %0d reported a covering window and %0d flagged an overflow.",
             board.windows_found, board.overflow_jobs);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/mcwf_pkg.sv
design/mcwf_ram.sv
design/mcwf_front.sv
design/mcwf_back.sv
design/min_covering_window_finder.sv
design/mcwf_checker.sv
tb/tb_min_covering_window_finder.sv
